### hw/rtl/ffcpt_pkg.sv
// Shared constants, codes and beat layouts of the full/free chunk partition table.
package ffcpt_pkg;

  // Table geometry
  localparam int unsigned MAX_CHUNKS = 64;
  localparam int unsigned FILL_W     = 16;
  localparam int unsigned ID_W       = 6;
  localparam int unsigned ID_SPACE   = 1 << ID_W;
  localparam int unsigned SLOT_W     = $clog2(MAX_CHUNKS);
  localparam int unsigned CNT_W      = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned TOTAL_W    = ID_W + FILL_W;
  localparam int unsigned ST_W       = 3;
  localparam int unsigned OP_W       = 2;

  // Input beat layout: op, chunk_id, fill_count, chunk_capacity
  localparam int unsigned IN_ID_LSB   = OP_W;
  localparam int unsigned IN_FILL_LSB = IN_ID_LSB + ID_W;
  localparam int unsigned IN_CAP_LSB  = IN_FILL_LSB + FILL_W;
  localparam int unsigned IN_FIELDS_W = IN_CAP_LSB + FILL_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output beat layout: status, has_free, first_free, held, full, total
  localparam int unsigned OUT_FIELDS_W = ST_W + 1 + ID_W + CNT_W + CNT_W + TOTAL_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_RESIZE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL_TABLE = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_OVER_CAP   = 3'd3,
    ST_DUPLICATE  = 3'd4
  } status_e;

endpackage

### hw/rtl/ffcpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffcpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/full_free_chunk_partition_table.sv
// Every beat ends in S_FETCH and S_OUT. Resizes of a known chunk read back in S_RSZ first; a
// fullness change adds S_SWAP and S_PLACE, a full add with nothing to shift S_PLACE; S_SHIFT
// moves one slot per cycle through the slot RAM when slots shift. Throughput: one beat at a
// time; the next beat is taken once the result sits in the output register. Reset clears the
// presence bits, counters, total and handshake state at once; the slot and chunk RAMs are not
// cleared and need no clearing pass.
module full_free_chunk_partition_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // op, chunk_id, fill_count, chunk_capacity (from bit 0 up)
  input  logic [ffcpt_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // status, has_free_chunk, first_free_chunk, chunks_held, full_chunks, entity_total, pad
  output logic [ffcpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i
);
  import ffcpt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RSZ   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SWAP  = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [ID_W-1:0]      id_q, id_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  status_e              status_q, status_d;
  logic [CNT_W-1:0]     boundary_q, boundary_d;
  logic [CNT_W-1:0]     held_q, held_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [ID_SPACE-1:0]  present_q, present_d;
  logic [SLOT_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [SLOT_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic                 pend_q, pend_d;
  logic                 left_q, left_d;
  logic [SLOT_W-1:0]    s_q, s_d;
  logic [SLOT_W-1:0]    t_q, t_d;
  logic                 m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // Input beat fields
  op_e               in_op;
  logic [ID_W-1:0]   in_id;
  logic [FILL_W-1:0] in_fill;
  logic [FILL_W-1:0] in_cap;
  logic              in_beat;

  assign in_op   = op_e'(s_axis_tdata_i[OP_W-1:0]);
  assign in_id   = s_axis_tdata_i[IN_ID_LSB +: ID_W];
  assign in_fill = s_axis_tdata_i[IN_FILL_LSB +: FILL_W];
  assign in_cap  = s_axis_tdata_i[IN_CAP_LSB +: FILL_W];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // RAM ports
  logic              s2c_we, s2c_re;
  logic [SLOT_W-1:0] s2c_waddr, s2c_raddr;
  logic [ID_W-1:0]   s2c_wdata, s2c_rdata;
  logic              c2s_we, c2s_re;
  logic [ID_W-1:0]   c2s_waddr, c2s_raddr;
  logic [SLOT_W-1:0] c2s_wdata, c2s_rdata;
  logic              fr_we, fr_re;
  logic [ID_W-1:0]   fr_waddr, fr_raddr;
  logic [2*FILL_W-1:0] fr_wdata, fr_rdata;

  // Resize read-back: stored fill and capacity
  logic [FILL_W-1:0] rd_room, rd_old;
  logic              was_full;
  logic              has_free;
  logic [ID_W-1:0]   first_free;

  assign rd_room  = fr_rdata[FILL_W-1:0];
  assign rd_old   = fr_rdata[2*FILL_W-1:FILL_W];
  assign was_full = (rd_old == rd_room);
  assign has_free = (boundary_q < held_q);
  assign first_free = has_free ? s2c_rdata : '0;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    id_d       = id_q;
    fill_d     = fill_q;
    status_d   = status_q;
    boundary_d = boundary_q;
    held_d     = held_q;
    total_d    = total_q;
    present_d  = present_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    rd_cnt_d   = rd_cnt_q;
    pend_d     = pend_q;
    left_d     = left_q;
    s_d        = s_q;
    t_d        = t_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    s2c_we = 1'b0; s2c_waddr = '0; s2c_wdata = '0;
    s2c_re = 1'b0; s2c_raddr = '0;
    c2s_we = 1'b0; c2s_waddr = '0; c2s_wdata = '0;
    c2s_re = 1'b0; c2s_raddr = '0;
    fr_we  = 1'b0; fr_waddr  = '0; fr_wdata  = '0;
    fr_re  = 1'b0; fr_raddr  = '0;

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          id_d     = in_id;
          fill_d   = in_fill;
          status_d = ST_OK;
          state_d  = S_FETCH;
          unique case (in_op)
            OP_ADD: begin
              priority if (present_q[in_id]) begin
                status_d = ST_DUPLICATE;
              end else if (held_q >= CNT_W'(MAX_CHUNKS)) begin
                status_d = ST_FULL_TABLE;
              end else if (in_fill > in_cap) begin
                status_d = ST_OVER_CAP;
              end else begin
                present_d[in_id] = 1'b1;
                total_d  = total_q + TOTAL_W'(in_fill);
                fr_we    = 1'b1;
                fr_waddr = in_id;
                fr_wdata = {in_fill, in_cap};
                held_d   = held_q + CNT_W'(1);
                if (in_fill < in_cap) begin
                  // chunk with room goes to the end
                  s2c_we    = 1'b1;
                  s2c_waddr = held_q[SLOT_W-1:0];
                  s2c_wdata = in_id;
                  c2s_we    = 1'b1;
                  c2s_waddr = in_id;
                  c2s_wdata = held_q[SLOT_W-1:0];
                end else begin
                  // full chunk goes in at the boundary after the room region moves up
                  boundary_d = boundary_q + CNT_W'(1);
                  t_d        = boundary_q[SLOT_W-1:0];
                  if (held_q == boundary_q) begin
                    state_d = S_PLACE;
                  end else begin
                    rd_cnt_d = held_q - boundary_q;
                    rd_ptr_d = held_q[SLOT_W-1:0] - SLOT_W'(1);
                    wr_ptr_d = held_q[SLOT_W-1:0];
                    pend_d   = 1'b0;
                    left_d   = 1'b0;
                    state_d  = S_SHIFT;
                  end
                end
              end
            end
            OP_RESIZE: begin
              if (!present_q[in_id]) begin
                status_d = ST_UNKNOWN;
              end else begin
                fr_re     = 1'b1;
                fr_raddr  = in_id;
                c2s_re    = 1'b1;
                c2s_raddr = in_id;
                state_d   = S_RSZ;
              end
            end
            OP_CLEAR: begin
              present_d  = '0;
              boundary_d = '0;
              held_d     = '0;
              total_d    = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_RSZ: begin
        state_d = S_FETCH;
        if (fill_q > rd_room) begin
          status_d = ST_OVER_CAP;
        end else begin
          total_d  = total_q + TOTAL_W'(fill_q) - TOTAL_W'(rd_old);
          fr_we    = 1'b1;
          fr_waddr = id_q;
          fr_wdata = {fill_q, rd_room};
          s_d      = c2s_rdata;
          if (fill_q == '0) begin
            // removal: later slots move down by one
            present_d[id_q] = 1'b0;
            held_d = held_q - CNT_W'(1);
            if (CNT_W'(c2s_rdata) < boundary_q) begin
              boundary_d = boundary_q - CNT_W'(1);
            end
            if (CNT_W'(c2s_rdata) + CNT_W'(1) < held_q) begin
              rd_cnt_d = held_q - CNT_W'(c2s_rdata) - CNT_W'(1);
              rd_ptr_d = c2s_rdata + SLOT_W'(1);
              wr_ptr_d = c2s_rdata;
              pend_d   = 1'b0;
              left_d   = 1'b1;
              state_d  = S_SHIFT;
            end
          end else if (!was_full && (fill_q == rd_room)) begin
            // becomes full: swap with the slot at the boundary
            t_d        = boundary_q[SLOT_W-1:0];
            boundary_d = boundary_q + CNT_W'(1);
            s2c_re     = 1'b1;
            s2c_raddr  = boundary_q[SLOT_W-1:0];
            state_d    = S_SWAP;
          end else if (was_full && (fill_q < rd_room)) begin
            // leaves full: swap with the last full slot
            t_d        = boundary_q[SLOT_W-1:0] - SLOT_W'(1);
            boundary_d = boundary_q - CNT_W'(1);
            s2c_re     = 1'b1;
            s2c_raddr  = boundary_q[SLOT_W-1:0] - SLOT_W'(1);
            state_d    = S_SWAP;
          end
        end
      end

      S_SHIFT: begin
        // reads run one slot ahead of the writes, never touching a written slot
        pend_d = (rd_cnt_q != '0);
        if (rd_cnt_q != '0) begin
          s2c_re    = 1'b1;
          s2c_raddr = rd_ptr_q;
          rd_ptr_d  = left_q ? rd_ptr_q + SLOT_W'(1) : rd_ptr_q - SLOT_W'(1);
          rd_cnt_d  = rd_cnt_q - CNT_W'(1);
        end
        if (pend_q) begin
          s2c_we    = 1'b1;
          s2c_waddr = wr_ptr_q;
          s2c_wdata = s2c_rdata;
          c2s_we    = 1'b1;
          c2s_waddr = s2c_rdata;
          c2s_wdata = wr_ptr_q;
          wr_ptr_d  = left_q ? wr_ptr_q + SLOT_W'(1) : wr_ptr_q - SLOT_W'(1);
          if (rd_cnt_q == '0) begin
            state_d = left_q ? S_FETCH : S_PLACE;
          end
        end
      end

      S_SWAP: begin
        // chunk from the target slot moves to the resized chunk's slot
        s2c_we    = 1'b1;
        s2c_waddr = s_q;
        s2c_wdata = s2c_rdata;
        c2s_we    = 1'b1;
        c2s_waddr = s2c_rdata;
        c2s_wdata = s_q;
        state_d   = S_PLACE;
      end

      S_PLACE: begin
        s2c_we    = 1'b1;
        s2c_waddr = t_q;
        s2c_wdata = id_q;
        c2s_we    = 1'b1;
        c2s_waddr = id_q;
        c2s_wdata = t_q;
        state_d   = S_FETCH;
      end

      S_FETCH: begin
        s2c_re    = 1'b1;
        s2c_raddr = boundary_q[SLOT_W-1:0];
        state_d   = S_OUT;
      end

      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {{OUT_PAD_W{1'b0}}, total_q, boundary_q, held_q,
                       first_free, has_free, status_q};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      boundary_q <= '0;
      held_q     <= '0;
      total_q    <= '0;
      present_q  <= '0;
      rd_cnt_q   <= '0;
      pend_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      boundary_q <= boundary_d;
      held_q     <= held_d;
      total_q    <= total_d;
      present_q  <= present_d;
      rd_cnt_q   <= rd_cnt_d;
      pend_q     <= pend_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    fill_q   <= fill_d;
    status_q <= status_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    left_q   <= left_d;
    s_q      <= s_d;
    t_q      <= t_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Slot to chunk handle
  ffcpt_ram #(.WIDTH(ID_W), .DEPTH(MAX_CHUNKS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s2c_we),
    .waddr_i (s2c_waddr),
    .wdata_i (s2c_wdata),
    .re_i    (s2c_re),
    .raddr_i (s2c_raddr),
    .rdata_o (s2c_rdata)
  );

  // Chunk handle to slot
  ffcpt_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (c2s_we),
    .waddr_i (c2s_waddr),
    .wdata_i (c2s_wdata),
    .re_i    (c2s_re),
    .raddr_i (c2s_raddr),
    .rdata_o (c2s_rdata)
  );

  // Chunk fill and capacity
  ffcpt_ram #(.WIDTH(2*FILL_W), .DEPTH(ID_SPACE)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  // Checks
  a_boundary_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    boundary_q <= held_q)
    else $error("boundary beyond held count");

  a_held_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(MAX_CHUNKS))
    else $error("held count beyond table size");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready_o)
    else $error("second beat taken while busy");

  a_fetch_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> (state_q == S_OUT))
    else $error("fetch not followed by output");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SHIFT) && pend_q) |-> (CNT_W'(wr_ptr_q) < held_q))
    else $error("shift writes beyond held slots");

endmodule

### tb/sv/tb.sv
// Testbench for the full/free chunk partition table: directed, back-pressure and random tests.
`timescale 1ns / 1ps

module tb;
  import ffcpt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = MAX_CHUNKS + 16;
  localparam int unsigned IDLE_PCT     = 37;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [FILL_W-1:0] FILL_MAX = '1;

  // Input beat fields, op in the low bits
  typedef struct packed {
    logic [FILL_W-1:0] cap;
    logic [FILL_W-1:0] fill;
    logic [ID_W-1:0]   id;
    logic [OP_W-1:0]   op;
  } table_cmd_t;

  // Output beat fields, status in the low bits
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [TOTAL_W-1:0]   entity_total;
    logic [CNT_W-1:0]     full_chunks;
    logic [CNT_W-1:0]     chunks_held;
    logic [ID_W-1:0]      first_free;
    logic                 has_free;
    logic [ST_W-1:0]      status;
  } table_reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;

  logic rx_idle_en = 1'b1;
  logic rx_hold = 1'b0;
  bit   tx_idle_en = 1'b1;

  int unsigned  cycles = 0;
  int unsigned  errors = 0;
  table_reply_t pending_replies[$];

  // Shadow copy of the table
  logic [ID_W-1:0]    tbl_slot_chunk[MAX_CHUNKS];
  logic [SLOT_W-1:0]  tbl_chunk_slot[ID_SPACE];
  logic [FILL_W-1:0]  tbl_fill[ID_SPACE];
  logic [FILL_W-1:0]  tbl_cap[ID_SPACE];
  logic [ID_SPACE-1:0] tbl_present = '0;
  int unsigned        tbl_boundary = 0;
  int unsigned        tbl_held = 0;
  logic [TOTAL_W-1:0] tbl_total = '0;

  always #10 clk_i = ~clk_i;

  full_free_chunk_partition_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  function automatic void place_chunk(int unsigned slot, logic [ID_W-1:0] id);
    tbl_slot_chunk[slot] = id;
    tbl_chunk_slot[id]   = slot[SLOT_W-1:0];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [ID_W-1:0] held_a;
    held_a = tbl_slot_chunk[a];
    place_chunk(a, tbl_slot_chunk[b]);
    place_chunk(b, held_a);
  endfunction

  // Update the shadow table with one accepted beat and return the reply it gives
  function automatic table_reply_t apply_table_op(table_cmd_t c);
    table_reply_t r;
    int unsigned  s;
    logic         was_full;
    r = '0;
    r.status = ST_OK;
    case (c.op)
      OP_ADD: begin
        if (tbl_present[c.id]) begin
          r.status = ST_DUPLICATE;
        end else if (tbl_held >= MAX_CHUNKS) begin
          r.status = ST_FULL_TABLE;
        end else if (c.fill > c.cap) begin
          r.status = ST_OVER_CAP;
        end else begin
          tbl_present[c.id] = 1'b1;
          tbl_fill[c.id]    = c.fill;
          tbl_cap[c.id]     = c.cap;
          tbl_total         = tbl_total + c.fill;
          if (c.fill < c.cap) begin
            place_chunk(tbl_held, c.id);
          end else begin
            // full chunk goes in at the boundary, room region moves right
            for (s = tbl_held; s > tbl_boundary; s--)
              place_chunk(s, tbl_slot_chunk[s-1]);
            place_chunk(tbl_boundary, c.id);
            tbl_boundary++;
          end
          tbl_held++;
        end
      end
      OP_RESIZE: begin
        if (!tbl_present[c.id]) begin
          r.status = ST_UNKNOWN;
        end else if (c.fill > tbl_cap[c.id]) begin
          r.status = ST_OVER_CAP;
        end else begin
          was_full       = (tbl_fill[c.id] == tbl_cap[c.id]);
          tbl_total      = tbl_total + c.fill - tbl_fill[c.id];
          tbl_fill[c.id] = c.fill;
          if (c.fill == '0) begin
            // removal: later slots move left
            s = tbl_chunk_slot[c.id];
            if (s < tbl_boundary) tbl_boundary--;
            for (; s + 1 < tbl_held; s++)
              place_chunk(s, tbl_slot_chunk[s+1]);
            tbl_held--;
            tbl_present[c.id] = 1'b0;
          end else if (!was_full && c.fill == tbl_cap[c.id]) begin
            swap_slots(tbl_chunk_slot[c.id], tbl_boundary);
            tbl_boundary++;
          end else if (was_full && c.fill < tbl_cap[c.id]) begin
            tbl_boundary--;
            swap_slots(tbl_chunk_slot[c.id], tbl_boundary);
          end
        end
      end
      OP_CLEAR: begin
        tbl_present  = '0;
        tbl_boundary = 0;
        tbl_held     = 0;
        tbl_total    = '0;
      end
      default: ;
    endcase
    r.has_free     = (tbl_boundary < tbl_held);
    r.first_free   = r.has_free ? tbl_slot_chunk[tbl_boundary] : '0;
    r.chunks_held  = tbl_held[CNT_W-1:0];
    r.full_chunks  = tbl_boundary[CNT_W-1:0];
    r.entity_total = tbl_total;
    return r;
  endfunction

  function automatic table_cmd_t make_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                          logic [FILL_W-1:0] fill, logic [FILL_W-1:0] cap);
    table_cmd_t c;
    c.op   = op;
    c.id   = id;
    c.fill = fill;
    c.cap  = cap;
    return c;
  endfunction

  // Mostly well-formed traffic against chunks that exist, some noise
  function automatic table_cmd_t random_table_cmd();
    table_cmd_t        c;
    int unsigned       pick;
    int unsigned       roll;
    int unsigned       zero_pct;
    logic [FILL_W-1:0] cap;
    c = make_cmd(OP_W'($urandom_range(3)), ID_W'($urandom_range(ID_SPACE - 1)),
                 FILL_W'($urandom), FILL_W'($urandom));
    pick = $urandom_range(99);
    roll = $urandom_range(99);
    if (pick < 38) begin
      c.op = OP_ADD;
      if (tbl_held < MAX_CHUNKS && $urandom_range(99) < 85) begin
        while (tbl_present[c.id]) c.id = ID_W'($urandom_range(ID_SPACE - 1));
      end
      if (roll < 3) c.cap = '0;
      else if (roll < 70) c.cap = FILL_W'($urandom_range(8, 1));
      roll = $urandom_range(99);
      if (roll < 30) c.fill = c.cap;
      else if (roll < 36 && c.cap != FILL_MAX)
        c.fill = FILL_W'($urandom_range(FILL_MAX, c.cap + 1));
      else c.fill = FILL_W'($urandom_range(c.cap, 0));
    end else if (pick < 91) begin
      c.op = OP_RESIZE;
      if (tbl_held > 0 && $urandom_range(99) < 92) begin
        while (!tbl_present[c.id]) c.id = ID_W'($urandom_range(ID_SPACE - 1));
      end
      cap = tbl_cap[c.id];
      zero_pct = (tbl_held > 56) ? 30 : 8;
      if (roll < zero_pct) c.fill = '0;
      else if (roll < zero_pct + 35) c.fill = cap;
      else if (roll < zero_pct + 40 && cap != FILL_MAX)
        c.fill = FILL_W'($urandom_range(FILL_MAX, cap + 1));
      else c.fill = FILL_W'($urandom_range(cap, 0));
    end else if (pick < 92) begin
      c.op = OP_CLEAR;
    end else if (pick < 95) begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  // Offer one beat, wait for the handshake and record its reply; valid stays up
  task automatic send_beat(table_cmd_t c);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(c);
    do @(posedge clk_i); while (!s_tready);
    pending_replies.insert(pending_replies.size(), apply_table_op(c));
  endtask

  task automatic test_directed();
    // zero fill, full-range fill and capacity, duplicate, over-capacity and unknown-chunk errors, zero capacity
    send_beat(make_cmd(OP_ADD, 6'd0, 16'd0, FILL_MAX));
    send_beat(make_cmd(OP_ADD, 6'd63, FILL_MAX, FILL_MAX));
    send_beat(make_cmd(OP_ADD, 6'd63, 16'd1, 16'd2));
    send_beat(make_cmd(OP_ADD, 6'd5, 16'd10, 16'd9));
    send_beat(make_cmd(OP_ADD, 6'd7, 16'd0, 16'd0));
    send_beat(make_cmd(OP_ADD, 6'd42, 16'd1, 16'd2));
    send_beat(make_cmd(OP_RESIZE, 6'd20, 16'd1, 16'd0));
    send_beat(make_cmd(OP_RESIZE, 6'd42, 16'd3, 16'd0));
    // chunk becomes full, leaves full, then changes fill within the room region
    send_beat(make_cmd(OP_RESIZE, 6'd0, FILL_MAX, 16'd0));
    send_beat(make_cmd(OP_RESIZE, 6'd0, 16'd1, 16'd0));
    send_beat(make_cmd(OP_RESIZE, 6'd0, 16'd2, 16'd0));
    // removals from the full region, of a zero-capacity chunk and from the room region
    send_beat(make_cmd(OP_RESIZE, 6'd63, 16'd0, 16'd0));
    send_beat(make_cmd(OP_RESIZE, 6'd7, 16'd0, 16'd0));
    send_beat(make_cmd(OP_RESIZE, 6'd42, 16'd0, 16'd0));
    send_beat(make_cmd(OP_UNUSED, 6'd21, 16'h5555, 16'hAAAA));
    send_beat(make_cmd(OP_ADD, 6'd21, 16'hAAAA, FILL_MAX));
    send_beat(make_cmd(OP_ADD, 6'd1, 16'd1, 16'd1));
    send_beat(make_cmd(OP_RESIZE, 6'd21, 16'h5555, 16'd0));
    send_beat(make_cmd(OP_CLEAR, 6'd21, 16'd0, 16'd0));
    // after clear the handle is gone and may come back
    send_beat(make_cmd(OP_RESIZE, 6'd21, 16'd1, 16'd0));
    send_beat(make_cmd(OP_ADD, 6'd21, 16'd0, 16'd1));
    send_beat(make_cmd(OP_CLEAR, 6'd0, 16'd0, 16'd0));
  endtask

  task automatic test_backpressure();
    // receiver stops for a long stretch while beats keep coming
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    tx_idle_en = 1'b0;
    repeat (25) send_beat(random_table_cmd());
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random();
    repeat (400) send_beat(random_table_cmd());
    // stretch with no idling on either side
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (300) send_beat(random_table_cmd());
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    repeat (480) send_beat(random_table_cmd());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver ready: random idling, or held low on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (rx_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_idle_en || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result beat with the oldest recorded reply
  always @(posedge clk_i) begin
    table_reply_t got;
    table_reply_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_replies.size() == 0) begin
        $error("result beat with no reply pending");
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.has_free != want.has_free) begin
          $error("has_free_chunk: expected %0d, got %0d", want.has_free, got.has_free);
          errors++;
        end
        if (got.first_free != want.first_free) begin
          $error("first_free_chunk: expected %0d, got %0d", want.first_free, got.first_free);
          errors++;
        end
        if (got.chunks_held != want.chunks_held) begin
          $error("chunks_held: expected %0d, got %0d", want.chunks_held, got.chunks_held);
          errors++;
        end
        if (got.full_chunks != want.full_chunks) begin
          $error("full_chunks: expected %0d, got %0d", want.full_chunks, got.full_chunks);
          errors++;
        end
        if (got.entity_total != want.entity_total) begin
          $error("entity_total: expected %0d, got %0d", want.entity_total, got.entity_total);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
